[rtl/chm_pkg.sv]
// Shared constants and types of the cookie handle map.
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;

  typedef logic [2:0] status_t;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_EXHAUSTED   = 3'd1;
  localparam status_t ST_ZERO_COOKIE = 3'd2;
  localparam status_t ST_BAD_INDEX   = 3'd3;
  localparam status_t ST_MISMATCH    = 3'd4;
  localparam status_t ST_ZERO_RANDOM = 3'd5;

endpackage
`default_nettype wire

[rtl/chm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/cookie_handle_map_core.sv]
// Top level of the cookie handle map: allocation and release of table entries.
// A get or put request is taken when start is high and busy is low. Requests
// that are settled without a table read (zero random word, allocation from the
// bump counter, exhaustion, zero cookie, bad index) show their result beat on
// the out_ ports in the following cycle. Requests that need the stored entry
// (allocation from the free list, every put that passes the index check) pass
// through the S_READ state, which waits for the registered read data of the
// entry memory; busy is high in S_READ and the result beat is registered at
// its end. Each result beat is shown for exactly one cycle with out_valid high
// and cannot be held off, and a new request may be taken in the cycle in which
// the previous result is shown. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module cookie_handle_map_core #(
  parameter int ENTRIES     = 1024,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_op,
  input  wire logic [31:0]           in_random_word,
  input  wire logic [31:0]           in_handle_in,
  input  wire logic [63:0]           in_cookie_in,
  output logic                       out_valid,
  output logic [63:0]                out_cookie_out,
  output logic [31:0]                out_handle_out,
  output chm_pkg::status_t           out_status
);
  import chm_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int RW = 32 + HW + CW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] bump_r, bump_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic          op_r, op_nxt;
  logic [31:0]   rnd_r, rnd_nxt;
  logic [HW-1:0] hnd_r, hnd_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic          ov_r, ov_nxt;
  logic [63:0]   oc_r, oc_nxt;
  logic [31:0]   oh_r, oh_nxt;
  status_t       os_r, os_nxt;

  logic          accept;
  logic [CW-1:0] head_m1;
  logic [31:0]   ck_hi;
  logic [31:0]   ck_lo;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [31:0]   rd_rnd;
  logic [HW-1:0] rd_hnd;
  logic [CW-1:0] rd_link;

  assign accept  = start && !busy;
  assign busy    = (state_r == S_READ);
  assign head_m1 = head_r - CW'(1);
  assign ck_hi   = in_cookie_in[63:32];
  assign ck_lo   = in_cookie_in[31:0];
  assign rd_rnd  = rdata[CW+HW +: 32];
  assign rd_hnd  = rdata[CW +: HW];
  assign rd_link = rdata[CW-1:0];
  assign raddr   = (in_op == OP_PUT) ? ck_hi[IW-1:0] : head_m1[IW-1:0];

  chm_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    bump_nxt  = bump_r;
    head_nxt  = head_r;
    op_nxt    = op_r;
    rnd_nxt   = rnd_r;
    hnd_nxt   = hnd_r;
    lo_nxt    = lo_r;
    idx_nxt   = idx_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    oh_nxt    = oh_r;
    os_nxt    = os_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          rnd_nxt = in_random_word;
          hnd_nxt = in_handle_in[HW-1:0];
          lo_nxt  = ck_lo;
          oc_nxt  = '0;
          oh_nxt  = '0;
          if (in_op == OP_GET) begin
            idx_nxt = head_m1[IW-1:0];
            if (in_random_word == 32'd0) begin
              ov_nxt = 1'b1;
              os_nxt = ST_ZERO_RANDOM;
            end else if (bump_r != CW'(ENTRIES)) begin
              we       = 1'b1;
              waddr    = bump_r[IW-1:0];
              wdata    = {in_random_word, in_handle_in[HW-1:0], {CW{1'b0}}};
              bump_nxt = bump_r + CW'(1);
              ov_nxt   = 1'b1;
              oc_nxt   = {32'(bump_r), in_random_word};
              os_nxt   = ST_OK;
            end else if (head_r != '0) begin
              state_nxt = S_READ;
            end else begin
              ov_nxt = 1'b1;
              os_nxt = ST_EXHAUSTED;
            end
          end else begin
            idx_nxt = ck_hi[IW-1:0];
            if (in_cookie_in == 64'd0) begin
              ov_nxt = 1'b1;
              os_nxt = ST_ZERO_COOKIE;
            end else if (ck_hi >= 32'(bump_r)) begin
              ov_nxt = 1'b1;
              os_nxt = ST_BAD_INDEX;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        if (op_r == OP_GET) begin
          we       = 1'b1;
          wdata    = {rnd_r, hnd_r, {CW{1'b0}}};
          head_nxt = rd_link;
          oc_nxt   = {32'(idx_r), rnd_r};
          os_nxt   = ST_OK;
        end else if (lo_r == 32'd0 || rd_rnd != lo_r) begin
          os_nxt = ST_MISMATCH;
        end else begin
          we       = 1'b1;
          wdata    = {32'd0, {HW{1'b0}}, head_r};
          head_nxt = CW'(idx_r) + CW'(1);
          oh_nxt   = 32'(rd_hnd);
          os_nxt   = ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bump_r  <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bump_r  <= bump_nxt;
      head_r  <= head_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    rnd_r <= rnd_nxt;
    hnd_r <= hnd_nxt;
    lo_r  <= lo_nxt;
    idx_r <= idx_nxt;
    oc_r  <= oc_nxt;
    oh_r  <= oh_nxt;
    os_r  <= os_nxt;
  end

  assign out_valid      = ov_r;
  assign out_cookie_out = oc_r;
  assign out_handle_out = oh_r;
  assign out_status     = os_r;

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("table read stage lasted more than one cycle");

  a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result beat shown during table read");

  a_zero_cookie: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_PUT && in_cookie_in == 64'd0)
      |=> (out_valid && out_status == ST_ZERO_COOKIE))
    else $error("zero cookie not reported");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK)
      |-> (out_cookie_out == 64'd0 && out_handle_out == 32'd0))
    else $error("error beat carries data");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= CW'(ENTRIES) && bump_r <= CW'(ENTRIES)))
    else $error("free list head or bump count out of range");

endmodule
`default_nettype wire
